### hdl/uv_sample_to_index_pipeline_assert.svh
// Assertion macros shared by the checker of the UV sample pipeline.
// Each macro expects signals named clk and arst_n in the scope where it is used.
`ifndef UV_SAMPLE_TO_INDEX_PIPELINE_ASSERT_SVH
`define UV_SAMPLE_TO_INDEX_PIPELINE_ASSERT_SVH

`define UVSI_ASSERT_IMPLY(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

`define UVSI_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

### hdl/uvsi_pkg.sv
package uvsi_pkg;

	localparam int VOLT_DEPTH_DEF = 128;
	localparam int UV_DEPTH_DEF   = 128;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [16:0] DIV3_MUL = 17'd43691;
	localparam logic [10:0] MV_SCALE = 11'd1200;

	typedef enum logic [1:0] {
		OP_SAMPLE  = 2'd0,
		OP_VOLT_WR = 2'd1,
		OP_UV_WR   = 2'd2
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ALARM_THRESHOLD = 3'd0,
		REG_ALARM_HOLD      = 3'd1,
		REG_REPORT_ENABLE   = 3'd2,
		REG_REPORT_PERIOD   = 3'd3,
		REG_VOLT_ENTRIES    = 3'd4,
		REG_UV_ENTRIES      = 3'd5
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_AVG,
		ST_MV,
		ST_VSCAN,
		ST_USCAN,
		ST_DONE
	} st_t;

	function automatic int clamp_count(input logic [7:0] n, input int depth);
		int r;
		r = int'(n);
		if (r == 0) begin
			r = 1;
		end else if (r > depth) begin
			r = depth;
		end
		return r;
	endfunction

endpackage

### hdl/uvsi_if.sv
interface uvsi_item_if;
	logic        valid;
	logic        ready;
	logic [1:0]  operation;
	logic [15:0] raw_sample;
	logic [6:0]  entry_index;
	logic [15:0] entry_key;
	logic [15:0] entry_value;

	modport source (output valid, operation, raw_sample, entry_index, entry_key, entry_value,
		input ready);
	modport sink (input valid, operation, raw_sample, entry_index, entry_key, entry_value,
		output ready);
endinterface

interface uvsi_result_if;
	logic        valid;
	logic        ready;
	logic [11:0] averaged_sample;
	logic [10:0] millivolts;
	logic [15:0] irradiance;
	logic [7:0]  uv_index;
	logic        alarm;
	logic        report_due;

	modport source (output valid, averaged_sample, millivolts, irradiance, uv_index, alarm,
		report_due, input ready);
	modport sink (input valid, averaged_sample, millivolts, irradiance, uv_index, alarm,
		report_due, output ready);
endinterface

interface uvsi_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [uvsi_pkg::CFG_IDX_W-1:0]  index;
	logic [uvsi_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

### hdl/uv_sample_to_index_pipeline.sv
// Channel  | Role   | Beat contents
// item     | sink   | operation, raw_sample (signed), entry_index, entry_key, entry_value
// result   | source | averaged_sample, millivolts, irradiance, uv_index, alarm, report_due
// cfg      | sink   | index of a register and its new value, always ready
//
// A table write gives no result. A sample passes through the AVG, MV, VSCAN, USCAN and DONE states,
// the scans reading V and U entries through the single table read ports, V and U being the clamped
// entry counts; its result is registered on leaving DONE, and the next beat can be taken then.
// Reset clears control state, history and counters and sets config registers to their defaults;
// tables are undefined until written. A stalled result holds in the output register while the
// next beat is accepted, and a finished sample waits in its last state only while that register is still full.
module uv_sample_to_index_pipeline #(
	parameter int VOLT_TABLE_DEPTH = uvsi_pkg::VOLT_DEPTH_DEF,
	parameter int UV_TABLE_DEPTH   = uvsi_pkg::UV_DEPTH_DEF
) (
	input logic            clk,
	input logic            arst_n,
	uvsi_item_if.sink      item,
	uvsi_result_if.source  result,
	uvsi_cfg_if.sink       cfg
);
	import uvsi_pkg::*;

	localparam int VAW  = $clog2(VOLT_TABLE_DEPTH);
	localparam int UAW  = $clog2(UV_TABLE_DEPTH);
	localparam int MAXD = (VOLT_TABLE_DEPTH > UV_TABLE_DEPTH) ? VOLT_TABLE_DEPTH : UV_TABLE_DEPTH;
	localparam int CW   = $clog2(MAXD + 1);

	st_t state_q, state_d;

	logic [7:0]  thr_q;
	logic [15:0] hold_q;
	logic        rpt_en_q;
	logic [7:0]  period_q;
	logic [7:0]  volt_entries_q;
	logic [7:0]  uv_entries_q;

	logic [11:0] hist0_q, hist1_q;
	logic [15:0] run_q;
	logic [7:0]  rpt_q;

	logic [31:0] volt_mem [VOLT_TABLE_DEPTH];
	logic [31:0] uv_mem [UV_TABLE_DEPTH];
	logic [31:0] vrd_q, urd_q;

	logic [13:0] sum_q;
	logic [11:0] avg_q;
	logic [10:0] mv_q;
	logic [15:0] irr_q;
	logic [CW-1:0] cnt_q;
	logic        rd_valid_s1;
	logic        best_found_q;
	logic [15:0] best_dist_q;
	logic [15:0] best_val_q;

	logic        out_valid_q;
	logic [11:0] out_avg_q;
	logic [10:0] out_mv_q;
	logic [15:0] out_irr_q;
	logic [7:0]  out_uvi_q;
	logic        out_alarm_q;
	logic        out_rpt_q;

	logic        item_acc, sample_acc;
	logic [11:0] clamped;
	logic [13:0] sum;
	logic [30:0] div_prod;
	logic [22:0] mv_prod;
	logic        scan_v, scan_u, issue, scan_end, better;
	logic [CW-1:0] vlim, ulim, lim;
	logic [31:0] rd_word;
	logic [15:0] x, key, gap;
	logic [7:0]  uvi;
	logic        over, fire, rpt_hit, out_free, finish;
	logic [16:0] run_inc;
	logic [8:0]  rpt_inc;
	logic [7:0]  period;

	assign item_acc   = item.valid && item.ready;
	assign sample_acc = item_acc && (item.operation == OP_SAMPLE);

	always_comb begin
		if (item.raw_sample[15]) begin
			clamped = 12'd0;
		end else if (item.raw_sample[14:12] != 3'd0) begin
			clamped = 12'hFFF;
		end else begin
			clamped = item.raw_sample[11:0];
		end
	end

	assign sum      = 14'(hist0_q) + 14'(hist1_q) + 14'(clamped);
	assign div_prod = 31'(sum_q) * 31'(DIV3_MUL);
	assign mv_prod  = 23'(avg_q) * 23'(MV_SCALE);

	assign vlim = CW'(clamp_count(volt_entries_q, VOLT_TABLE_DEPTH));
	assign ulim = CW'(clamp_count(uv_entries_q, UV_TABLE_DEPTH));

	assign scan_v   = (state_q == ST_VSCAN);
	assign scan_u   = (state_q == ST_USCAN);
	assign lim      = scan_v ? vlim : ulim;
	assign issue    = (scan_v || scan_u) && (cnt_q < lim);
	assign scan_end = (scan_v || scan_u) && !issue && !rd_valid_s1;
	assign rd_word  = scan_v ? vrd_q : urd_q;
	assign x        = scan_v ? 16'(mv_q) : irr_q;
	assign key      = rd_word[31:16];
	assign gap      = (x >= key) ? (x - key) : (key - x);
	assign better   = rd_valid_s1 && (!best_found_q || (gap < best_dist_q));

	assign uvi      = (best_val_q > 16'd255) ? 8'hFF : best_val_q[7:0];
	assign over     = uvi > thr_q;
	assign run_inc  = 17'(run_q) + 17'd1;
	assign fire     = over && (run_inc > 17'(hold_q));
	assign period   = (period_q == 8'd0) ? 8'd1 : period_q;
	assign rpt_inc  = 9'(rpt_q) + 9'd1;
	assign rpt_hit  = rpt_inc >= 9'(period);
	assign out_free = !out_valid_q || result.ready;
	assign finish   = (state_q == ST_DONE) && out_free;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (sample_acc) state_d = ST_AVG;
			end
			ST_AVG: state_d = ST_MV;
			ST_MV: state_d = ST_VSCAN;
			ST_VSCAN: begin
				if (scan_end) state_d = ST_USCAN;
			end
			ST_USCAN: begin
				if (scan_end) state_d = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Tables are written only in the idle state and read only while scanning,
	// so a write and a read of the same entry never overlap.
	always_comb begin
		item.ready = (state_q == ST_IDLE);
		cfg.ready  = 1'b1;
	end

	always_ff @(posedge clk) begin
		if (item_acc && (item.operation == OP_VOLT_WR)
				&& (int'(item.entry_index) < VOLT_TABLE_DEPTH)) begin
			volt_mem[VAW'(item.entry_index)] <= {item.entry_key, item.entry_value};
		end
		if (issue && scan_v) begin
			vrd_q <= volt_mem[cnt_q[VAW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (item_acc && (item.operation == OP_UV_WR)
				&& (int'(item.entry_index) < UV_TABLE_DEPTH)) begin
			uv_mem[UAW'(item.entry_index)] <= {item.entry_key, item.entry_value};
		end
		if (issue && scan_u) begin
			urd_q <= uv_mem[cnt_q[UAW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			thr_q          <= 8'd20;
			hold_q         <= 16'd180;
			rpt_en_q       <= 1'b0;
			period_q       <= 8'd5;
			volt_entries_q <= 8'd82;
			uv_entries_q   <= 8'd114;
			hist0_q        <= '0;
			hist1_q        <= '0;
			run_q          <= '0;
			rpt_q          <= '0;
			cnt_q          <= '0;
			rd_valid_s1    <= 1'b0;
			best_found_q   <= 1'b0;
			out_valid_q    <= 1'b0;
		end else begin
			state_q     <= state_d;
			rd_valid_s1 <= issue;
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					REG_ALARM_THRESHOLD: thr_q <= cfg.data[7:0];
					REG_ALARM_HOLD: hold_q <= cfg.data;
					REG_REPORT_ENABLE: rpt_en_q <= cfg.data[0];
					REG_REPORT_PERIOD: period_q <= cfg.data[7:0];
					REG_VOLT_ENTRIES: volt_entries_q <= cfg.data[7:0];
					REG_UV_ENTRIES: uv_entries_q <= cfg.data[7:0];
					default: ;
				endcase
			end
			if (sample_acc) begin
				hist0_q <= hist1_q;
				hist1_q <= clamped;
			end
			if (state_q == ST_MV) begin
				cnt_q        <= '0;
				best_found_q <= 1'b0;
			end else if (scan_end) begin
				cnt_q        <= '0;
				best_found_q <= 1'b0;
			end else begin
				if (issue) cnt_q <= cnt_q + CW'(1);
				if (better) best_found_q <= 1'b1;
			end
			if (finish) begin
				out_valid_q <= 1'b1;
				run_q       <= (over && !fire) ? run_inc[15:0] : 16'd0;
				rpt_q       <= rpt_hit ? 8'd0 : rpt_inc[7:0];
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (sample_acc) sum_q <= sum;
		if (state_q == ST_AVG) avg_q <= div_prod[28:17];
		if (state_q == ST_MV) mv_q <= mv_prod[22:12];
		if (better) begin
			best_dist_q <= gap;
			best_val_q  <= rd_word[15:0];
		end
		if (scan_end && scan_v) irr_q <= best_val_q;
		if (finish) begin
			out_avg_q   <= avg_q;
			out_mv_q    <= mv_q;
			out_irr_q   <= irr_q;
			out_uvi_q   <= uvi;
			out_alarm_q <= fire;
			out_rpt_q   <= rpt_hit && rpt_en_q;
		end
	end

	always_comb begin
		result.valid           = out_valid_q;
		result.averaged_sample = out_avg_q;
		result.millivolts      = out_mv_q;
		result.irradiance      = out_irr_q;
		result.uv_index        = out_uvi_q;
		result.alarm           = out_alarm_q;
		result.report_due      = out_rpt_q;
	end

endmodule

### hdl/uvsi_checker.sv
`include "uv_sample_to_index_pipeline_assert.svh"

module uvsi_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        item_valid,
	input logic        item_ready,
	input logic [1:0]  item_operation,
	input logic        result_valid,
	input logic        result_ready,
	input logic [48:0] result_beat,
	input logic        cfg_ready
);
	import uvsi_pkg::*;

	logic sample_acc;

	assign sample_acc = item_valid && item_ready && (item_operation == OP_SAMPLE);

	`UVSI_ASSERT_NEXT(a_result_held, result_valid && !result_ready, result_valid)
	`UVSI_ASSERT_NEXT(a_beat_stable, result_valid && !result_ready, $stable(result_beat))
	`UVSI_ASSERT_NEXT(a_busy_after_sample, sample_acc, !item_ready)
	`UVSI_ASSERT_IMPLY(a_result_after_busy, $rose(result_valid), $past(!item_ready) && cfg_ready)

endmodule

bind uv_sample_to_index_pipeline uvsi_checker u_uvsi_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.item_valid     (item.valid),
	.item_ready     (item.ready),
	.item_operation (item.operation),
	.result_valid   (result.valid),
	.result_ready   (result.ready),
	.result_beat    ({result.averaged_sample, result.millivolts, result.irradiance,
		result.uv_index, result.alarm, result.report_due}),
	.cfg_ready      (cfg.ready)
);
